[rtl/core/lav_pkg.sv]
// ---------------------------------------------------------------------------
// lav_pkg: shared types and constants for the look-at view matrix block
// Holds the channel payload types, the queue entry and matrix hand-off
// types, the fixed-point format and the translation rounding function.
// ---------------------------------------------------------------------------
package lav_pkg;

    // Fixed-point format and derived constants.
    localparam int FRAC_BITS = 16;
    localparam int QBITS     = FRAC_BITS + 2;
    localparam int QDEPTH    = 2;
    localparam logic [31:0] ONE_FX = 32'(64'd1 << FRAC_BITS);

    // Input item: camera position and target point.
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } in_item_t;

    // Result item: one matrix column.
    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem_row0;
        logic signed [31:0] elem_row1;
        logic signed [31:0] elem_row2;
        logic signed [31:0] elem_row3;
        logic               last_column;
        logic               degenerate;
    } out_item_t;

    // Classified item waiting for the back end.
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][32:0] dif;
        logic             deg;
    } queue_entry_t;

    // Finished matrix handed to the column emitter.
    typedef struct packed {
        logic [2:0][31:0] rgt;
        logic [2:0][31:0] upv;
        logic [2:0][31:0] fwd;
        logic [2:0][31:0] trn;
        logic             deg;
    } matrix_t;

    // Round a product sum with 2*FRAC_BITS fraction bits to FRAC_BITS,
    // ties away from zero, and saturate to the signed 32-bit range.
    function automatic logic [31:0] round_sat(input logic signed [63:0] x);
        logic [63:0] mag;
        logic [63:0] q;
        logic [31:0] res;
        mag = x[63] ? 64'(-x) : 64'(x);
        q   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (x[63])
        begin
            res = (q > 64'h8000_0000) ? 32'h8000_0000 : 32'(64'd0 - q);
        end
        else
        begin
            res = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return res;
    endfunction

endpackage

[rtl/core/lav_front.sv]
// ---------------------------------------------------------------------------
// lav_front: input stage
// Accepts an item, forms the full-width view direction target - position
// and flags items whose forward or right vector is zero.
// ---------------------------------------------------------------------------
module lav_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  lav_pkg::in_item_t     in_item,
    output logic                  push_valid,
    input  logic                  push_ready,
    output lav_pkg::queue_entry_t push_entry
);
    import lav_pkg::*;

    logic         valid_reg;
    queue_entry_t entry_reg;
    queue_entry_t entry_next;
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    logic signed [32:0] dz;

    // Differences at 33 bits never wrap.
    assign dx = 33'(in_item.target_x) - 33'(in_item.pos_x);
    assign dy = 33'(in_item.target_y) - 33'(in_item.pos_y);
    assign dz = 33'(in_item.target_z) - 33'(in_item.pos_z);

    // Right vector is (-dz, 0, dx); it is zero whenever the forward one is.
    always_comb
    begin
        entry_next.pos[0] = in_item.pos_x;
        entry_next.pos[1] = in_item.pos_y;
        entry_next.pos[2] = in_item.pos_z;
        entry_next.dif[0] = dx;
        entry_next.dif[1] = dy;
        entry_next.dif[2] = dz;
        entry_next.deg    = (dx == '0) && (dz == '0);
    end

    assign in_ready   = !valid_reg || push_ready;
    assign push_valid = valid_reg;
    assign push_entry = entry_reg;

    // Stage valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

[rtl/core/lav_fifo.sv]
// ---------------------------------------------------------------------------
// lav_fifo: queue between front and back end
// A short first-in first-out buffer of classified items.
// ---------------------------------------------------------------------------
module lav_fifo (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    output logic                  push_ready,
    input  lav_pkg::queue_entry_t push_entry,
    output logic                  pop_valid,
    input  logic                  pop_ready,
    output lav_pkg::queue_entry_t pop_entry
);
    import lav_pkg::*;

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);

    queue_entry_t  mem_reg [QDEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (count_reg != CW'(QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(QDEPTH - 1)) ? '0 : PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(QDEPTH - 1)) ? '0 : PW'(rd_ptr_reg + 1'b1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= CW'(count_reg + 1'b1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= CW'(count_reg - 1'b1);
            end
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

[rtl/core/lav_core.sv]
// ---------------------------------------------------------------------------
// lav_core: matrix engine
// Sequencer around one shared multiplier, a bit-serial square root and a
// bit-serial divider. Normalizes forward, right and true up vectors, forms
// the cross product and the translation dot products.
// ---------------------------------------------------------------------------
module lav_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pop_valid,
    output logic                  pop_ready,
    input  lav_pkg::queue_entry_t pop_entry,
    output logic                  mat_valid,
    input  logic                  mat_ready,
    output lav_pkg::matrix_t      mat
);
    import lav_pkg::*;

    localparam int DW = (QBITS > 1) ? $clog2(QBITS) : 1;

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b00_0000_0001,
        ST_LOAD  = 10'b00_0000_0010,
        ST_SHIFT = 10'b00_0000_0100,
        ST_SQ    = 10'b00_0000_1000,
        ST_SQRT  = 10'b00_0001_0000,
        ST_DIVI  = 10'b00_0010_0000,
        ST_DIV   = 10'b00_0100_0000,
        ST_CROSS = 10'b00_1000_0000,
        ST_DOT   = 10'b01_0000_0000,
        ST_DONE  = 10'b10_0000_0000
    } state_t;

    typedef enum logic [1:0] {
        VEC_FWD   = 2'd0,
        VEC_RIGHT = 2'd1,
        VEC_UP    = 2'd2
    } vec_kind_t;

    state_t    state_reg;
    state_t    state_next;
    vec_kind_t kind_reg;
    logic      deg_reg;

    logic signed [31:0] p_reg [3];
    logic signed [32:0] d_reg [3];
    logic signed [63:0] v_reg [3];
    logic [63:0]        mag_reg [3];
    logic               sgn_reg [3];
    logic signed [31:0] f_reg [3];
    logic signed [31:0] r_reg [3];
    logic signed [31:0] u_reg [3];
    logic signed [63:0] dot_reg [3];
    logic [63:0]        acc_reg;
    logic [63:0]        sq_n_reg;
    logic [63:0]        sq_res_reg;
    logic [63:0]        sq_bit_reg;
    logic [32:0]        len_reg;
    logic [33:0]        rem_reg;
    logic [QBITS-1:0]   low_reg;
    logic [QBITS-1:0]   quo_reg;
    logic [DW-1:0]      dcnt_reg;
    logic [2:0]         step_reg;
    logic [1:0]         row_reg;
    logic [1:0]         comp_reg;

    // Shared multiplier.
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic signed [63:0] prod;

    // Magnitude range checks for the shift search.
    logic any_hi;
    logic all_lo;
    logic all_zero;

    // Square root step.
    logic [63:0] sq_try;
    logic        sq_take;

    // Divider step.
    logic [63:0]      num;
    logic [33:0]      rem_sh;
    logic             div_ge;
    logic [QBITS-1:0] quo_new;
    logic [31:0]      qval;
    logic             div_last;

    // Dot product operand and running sum.
    logic signed [31:0] dot_vec;
    logic signed [63:0] dot_sum;

    assign any_hi   = (|mag_reg[0][63:31]) || (|mag_reg[1][63:31]) || (|mag_reg[2][63:31]);
    assign all_lo   = !((|mag_reg[0][63:30]) || (|mag_reg[1][63:30]) || (|mag_reg[2][63:30]));
    assign all_zero = (v_reg[0] == '0) && (v_reg[1] == '0) && (v_reg[2] == '0);

    assign sq_try  = sq_res_reg + sq_bit_reg;
    assign sq_take = (sq_n_reg >= sq_try);

    assign num      = (64'(mag_reg[step_reg[1:0]][30:0]) << FRAC_BITS) + 64'(len_reg >> 1);
    assign rem_sh   = {rem_reg[32:0], low_reg[QBITS-1]};
    assign div_ge   = (rem_sh >= {1'b0, len_reg});
    assign quo_new  = {quo_reg[QBITS-2:0], div_ge};
    assign qval     = sgn_reg[step_reg[1:0]] ? 32'(32'd0 - 32'(quo_new)) : 32'(quo_new);
    assign div_last = (dcnt_reg == DW'(QBITS - 1));

    always_comb
    begin
        case (row_reg)
            2'd0:    dot_vec = r_reg[comp_reg];
            2'd1:    dot_vec = u_reg[comp_reg];
            default: dot_vec = f_reg[comp_reg];
        endcase
    end

    // Multiplier operand selection.
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        if (state_reg == ST_SQ)
        begin
            mul_a = {2'b00, mag_reg[step_reg[1:0]][30:0]};
            mul_b = {2'b00, mag_reg[step_reg[1:0]][30:0]};
        end
        else if (state_reg == ST_CROSS)
        begin
            case (step_reg)
                3'd0:    begin mul_a = 33'(r_reg[1]); mul_b = 33'(f_reg[2]); end
                3'd1:    begin mul_a = 33'(f_reg[1]); mul_b = 33'(r_reg[2]); end
                3'd2:    begin mul_a = 33'(r_reg[2]); mul_b = 33'(f_reg[0]); end
                3'd3:    begin mul_a = 33'(f_reg[2]); mul_b = 33'(r_reg[0]); end
                3'd4:    begin mul_a = 33'(r_reg[0]); mul_b = 33'(f_reg[1]); end
                default: begin mul_a = 33'(f_reg[0]); mul_b = 33'(r_reg[1]); end
            endcase
        end
        else
        begin
            mul_a = 33'(dot_vec);
            mul_b = 33'(p_reg[comp_reg]);
        end
    end

    assign mul_p   = mul_a * mul_b;
    assign prod    = mul_p[63:0];
    assign dot_sum = ((comp_reg == 2'd0) ? 64'sd0 : $signed(acc_reg)) + prod;

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_entry.deg ? ST_DONE : ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = all_zero ? ST_DONE : ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (!any_hi && !all_lo)
                begin
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                if (step_reg == 3'd2)
                begin
                    state_next = ST_SQRT;
                end
            end
            ST_SQRT:
            begin
                if (sq_bit_reg == 64'd1)
                begin
                    state_next = ST_DIVI;
                end
            end
            ST_DIVI:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_last)
                begin
                    if (step_reg != 3'd2)
                    begin
                        state_next = ST_DIVI;
                    end
                    else
                    begin
                        unique case (kind_reg)
                            VEC_FWD:   state_next = ST_LOAD;
                            VEC_RIGHT: state_next = ST_CROSS;
                            default:   state_next = ST_DOT;
                        endcase
                    end
                end
            end
            ST_CROSS:
            begin
                if (step_reg == 3'd5)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_DOT:
            begin
                if ((row_reg == 2'd2) && (comp_reg == 2'd2))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (mat_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg  <= VEC_FWD;
            deg_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_IDLE) && pop_valid)
            begin
                kind_reg <= VEC_FWD;
                deg_reg  <= pop_entry.deg;
            end
            else if ((state_reg == ST_LOAD) && all_zero)
            begin
                deg_reg <= 1'b1;
            end
            else if ((state_reg == ST_DIV) && div_last && (step_reg == 3'd2))
            begin
                if (kind_reg == VEC_FWD)
                begin
                    kind_reg <= VEC_RIGHT;
                end
                else if (kind_reg == VEC_RIGHT)
                begin
                    kind_reg <= VEC_UP;
                end
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    p_reg[i] <= $signed(pop_entry.pos[i]);
                    d_reg[i] <= $signed(pop_entry.dif[i]);
                    v_reg[i] <= 64'($signed(pop_entry.dif[i]));
                end
            end
            ST_LOAD:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= v_reg[i][63] ? 64'(-v_reg[i]) : 64'(v_reg[i]);
                    sgn_reg[i] <= v_reg[i][63];
                end
            end
            ST_SHIFT:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (any_hi)
                    begin
                        mag_reg[i] <= mag_reg[i] >> 1;
                    end
                    else if (all_lo)
                    begin
                        mag_reg[i] <= mag_reg[i] << 1;
                    end
                end
                acc_reg  <= '0;
                step_reg <= '0;
            end
            ST_SQ:
            begin
                acc_reg  <= acc_reg + 64'(prod);
                step_reg <= 3'(step_reg + 1'b1);
                sq_n_reg   <= acc_reg + 64'(prod);
                sq_res_reg <= '0;
                sq_bit_reg <= 64'd1 << 62;
            end
            ST_SQRT:
            begin
                if (sq_take)
                begin
                    sq_n_reg   <= sq_n_reg - sq_try;
                    sq_res_reg <= (sq_res_reg >> 1) + sq_bit_reg;
                    len_reg    <= 33'((sq_res_reg >> 1) + sq_bit_reg);
                end
                else
                begin
                    sq_res_reg <= sq_res_reg >> 1;
                    len_reg    <= 33'(sq_res_reg >> 1);
                end
                sq_bit_reg <= sq_bit_reg >> 2;
                step_reg   <= '0;
            end
            ST_DIVI:
            begin
                rem_reg  <= 34'(num >> QBITS);
                low_reg  <= num[QBITS-1:0];
                quo_reg  <= '0;
                dcnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg  <= div_ge ? 34'(rem_sh - {1'b0, len_reg}) : rem_sh;
                low_reg  <= low_reg << 1;
                quo_reg  <= quo_new;
                dcnt_reg <= DW'(dcnt_reg + 1'b1);
                if (div_last)
                begin
                    unique case (kind_reg)
                        VEC_FWD:   f_reg[step_reg[1:0]] <= qval;
                        VEC_RIGHT: r_reg[step_reg[1:0]] <= qval;
                        default:   u_reg[step_reg[1:0]] <= qval;
                    endcase
                    if (step_reg == 3'd2)
                    begin
                        // Set up the right vector (-dz, 0, dx) after forward.
                        v_reg[0] <= 64'(-64'(d_reg[2]));
                        v_reg[1] <= '0;
                        v_reg[2] <= 64'(d_reg[0]);
                        step_reg <= '0;
                        row_reg  <= '0;
                        comp_reg <= '0;
                    end
                    else
                    begin
                        step_reg <= 3'(step_reg + 1'b1);
                    end
                end
            end
            ST_CROSS:
            begin
                // Even steps start a component, odd steps subtract.
                if (step_reg[0])
                begin
                    v_reg[step_reg[2:1]] <= v_reg[step_reg[2:1]] - prod;
                end
                else
                begin
                    v_reg[step_reg[2:1]] <= prod;
                end
                step_reg <= 3'(step_reg + 1'b1);
            end
            ST_DOT:
            begin
                acc_reg <= 64'(dot_sum);
                if (comp_reg == 2'd2)
                begin
                    dot_reg[row_reg] <= dot_sum;
                    comp_reg         <= '0;
                    row_reg          <= 2'(row_reg + 1'b1);
                end
                else
                begin
                    comp_reg <= 2'(comp_reg + 1'b1);
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Hand-off to the column emitter.
    assign pop_ready = (state_reg == ST_IDLE);
    assign mat_valid = (state_reg == ST_DONE);

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            mat.rgt[i] = r_reg[i];
            mat.upv[i] = u_reg[i];
            mat.fwd[i] = f_reg[i];
        end
        mat.trn[0] = round_sat(-dot_reg[0]);
        mat.trn[1] = round_sat(-dot_reg[1]);
        mat.trn[2] = round_sat(dot_reg[2]);
        mat.deg    = deg_reg;
    end

endmodule

[rtl/core/lav_emit.sv]
// ---------------------------------------------------------------------------
// lav_emit: column emitter
// Holds one finished matrix and sends it as four column transfers, so the
// engine can start the next item while the receiver takes this one.
// ---------------------------------------------------------------------------
module lav_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               mat_valid,
    output logic               mat_ready,
    input  lav_pkg::matrix_t   mat,
    output logic               out_valid,
    input  logic               out_ready,
    output lav_pkg::out_item_t out_item
);
    import lav_pkg::*;

    logic       busy_reg;
    logic [1:0] col_reg;
    matrix_t    mat_reg;
    logic       out_xfer;

    assign out_xfer  = out_valid && out_ready;
    assign out_valid = busy_reg;
    assign mat_ready = !busy_reg || (out_ready && (col_reg == 2'd3));

    // Column counter and busy flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            col_reg  <= '0;
        end
        else if (mat_valid && mat_ready)
        begin
            busy_reg <= 1'b1;
            col_reg  <= '0;
        end
        else if (out_xfer)
        begin
            col_reg <= 2'(col_reg + 1'b1);
            if (col_reg == 2'd3)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Held matrix.
    always_ff @(posedge clk)
    begin
        if (mat_valid && mat_ready)
        begin
            mat_reg <= mat;
        end
    end

    // Column selection; rows are right, true up and minus forward.
    always_comb
    begin
        out_item.column_index = col_reg;
        out_item.last_column  = (col_reg == 2'd3);
        out_item.degenerate   = mat_reg.deg;
        case (col_reg)
            2'd0:
            begin
                out_item.elem_row0 = mat_reg.rgt[0];
                out_item.elem_row1 = mat_reg.upv[0];
                out_item.elem_row2 = 32'(32'd0 - mat_reg.fwd[0]);
                out_item.elem_row3 = '0;
            end
            2'd1:
            begin
                out_item.elem_row0 = mat_reg.rgt[1];
                out_item.elem_row1 = mat_reg.upv[1];
                out_item.elem_row2 = 32'(32'd0 - mat_reg.fwd[1]);
                out_item.elem_row3 = '0;
            end
            2'd2:
            begin
                out_item.elem_row0 = mat_reg.rgt[2];
                out_item.elem_row1 = mat_reg.upv[2];
                out_item.elem_row2 = 32'(32'd0 - mat_reg.fwd[2]);
                out_item.elem_row3 = '0;
            end
            default:
            begin
                out_item.elem_row0 = mat_reg.trn[0];
                out_item.elem_row1 = mat_reg.trn[1];
                out_item.elem_row2 = mat_reg.trn[2];
                out_item.elem_row3 = ONE_FX;
            end
        endcase
        if (mat_reg.deg)
        begin
            out_item.elem_row0 = '0;
            out_item.elem_row1 = '0;
            out_item.elem_row2 = '0;
            out_item.elem_row3 = '0;
        end
    end

endmodule

[rtl/core/look_at_view_matrix.sv]
// ---------------------------------------------------------------------------
// look_at_view_matrix: look-at view matrix in signed fixed point
// Builds the column-major 4x4 view matrix for a camera position and target
// with world up (0,1,0) and sends it as four column transfers.
// ---------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_item) takes one position and
// target per transfer. The output channel (out_valid, out_ready, out_item)
// returns four transfers per input, columns 0 to 3, last_column on column 3.
// A degenerate view (zero forward, right or true up vector) sends four
// columns with degenerate set and all elements zero.
// The engine normalizes three vectors, each with a load step, a shift
// search, 3 multiply steps, 32 square root steps and 3 * (FRAC_BITS + 3)
// divide steps, then 6 cross and 9 dot product steps. A degenerate item
// leaves the engine early. Items pass the input stage and queue first.
// A two-entry queue and an input stage let new items be taken while the
// engine works; the emitter holds a finished matrix so the engine can start
// the next item while the receiver takes columns. When the receiver stalls,
// the column on out_item holds and the engine waits after its next matrix.
// Reset empties the queue, stages and emitter; no output is valid after it.
// ---------------------------------------------------------------------------
module look_at_view_matrix (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  lav_pkg::in_item_t  in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output lav_pkg::out_item_t out_item
);
    import lav_pkg::*;

    logic         push_valid;
    logic         push_ready;
    queue_entry_t push_entry;
    logic         pop_valid;
    logic         pop_ready;
    queue_entry_t pop_entry;
    logic         mat_valid;
    logic         mat_ready;
    matrix_t      mat;

    lav_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    lav_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    lav_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat)
    );

    lav_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat       (mat),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

[rtl/core/lav_checker.sv]
// ---------------------------------------------------------------------------
// lav_checker: port-level checks for the look-at view matrix block
// Watches the output channel for column order and matrix structure.
// ---------------------------------------------------------------------------
module lav_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_ready,
    input lav_pkg::out_item_t out_item
);
    import lav_pkg::*;

    // A stalled column holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("output column changed while stalled");

    // Columns of one matrix follow without a gap, in order.
    a_col_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_item.last_column |=>
            out_valid && (out_item.column_index == 2'($past(out_item.column_index) + 2'd1)))
        else $error("column sequence broken");

    // The last column flag marks column 3 only.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.last_column == (out_item.column_index == 2'd3)))
        else $error("last column flag wrong");

    // A degenerate matrix carries zero elements.
    a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_item.degenerate |->
            (out_item.elem_row0 == '0) && (out_item.elem_row1 == '0) &&
            (out_item.elem_row2 == '0) && (out_item.elem_row3 == '0))
        else $error("degenerate column has nonzero elements");

    // Bottom row is (0, 0, 0, 1) for a valid matrix.
    a_row3: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_item.degenerate |->
            (out_item.elem_row3 == ((out_item.column_index == 2'd3) ? ONE_FX : 32'd0)))
        else $error("bottom row element wrong");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

[tb/look_at_view_matrix_test.sv]
// ---------------------------------------------------------------------------
// look_at_view_matrix_test: self-checking bench for the look-at view matrix
// Drives camera position and target pairs with random idling on both sides
// and compares each column transfer against a bit-exact fixed-point model.
// ---------------------------------------------------------------------------
module look_at_view_matrix_test;

    timeunit 1ns;
    timeprecision 1ps;

    import lav_pkg::*;

    // Holds the expected columns and counts mismatches.
    class column_scoreboard;
        out_item_t pending_columns[$];
        int        error_count;

        // Magnitude-normalize a vector the same way the hardware does.
        function automatic bit unit_vector(input longint v[3], output longint o[3]);
            longint unsigned mag[3];
            longint unsigned m;
            longint unsigned s;
            longint unsigned len;
            longint unsigned q;
            m = 0;
            for (int i = 0; i < 3; i++)
            begin
                mag[i] = v[i] < 0 ? -v[i] : v[i];
                if (mag[i] > m)
                    m = mag[i];
            end
            if (m == 0)
                return 0;
            while (m >= (64'd1 << 31))
            begin
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] >> 1;
                m = m >> 1;
            end
            while (m < (64'd1 << 30))
            begin
                for (int i = 0; i < 3; i++)
                    mag[i] = mag[i] << 1;
                m = m << 1;
            end
            s = 0;
            for (int i = 0; i < 3; i++)
                s += mag[i] * mag[i];
            len = int_sqrt(s);
            for (int i = 0; i < 3; i++)
            begin
                q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
                o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            return 1;
        endfunction

        function automatic longint unsigned int_sqrt(input longint unsigned n);
            longint unsigned res;
            longint unsigned b;
            res = 0;
            b = 64'd1 << 62;
            while (b > n)
                b = b >> 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b = b >> 2;
            end
            return res;
        endfunction

        // Round a product sum to the output format and saturate it.
        function automatic logic [31:0] round_clip(input longint x);
            longint unsigned mag;
            longint unsigned q;
            mag = x < 0 ? -x : x;
            q = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
            if (x < 0)
                return q > 64'h8000_0000 ? 32'h8000_0000 : 32'(-longint'(q));
            return q > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : q[31:0];
        endfunction

        // Compute the four expected columns of an accepted transfer.
        function void note_view(input in_item_t it);
            longint p[3];
            longint d[3];
            longint rv[3];
            longint f[3];
            longint r[3];
            longint uv[3];
            longint u[3];
            logic [31:0] mtx[4][4];
            bit ok;
            out_item_t col;
            p[0] = it.pos_x;
            p[1] = it.pos_y;
            p[2] = it.pos_z;
            d[0] = longint'(it.target_x) - p[0];
            d[1] = longint'(it.target_y) - p[1];
            d[2] = longint'(it.target_z) - p[2];
            rv[0] = -d[2];
            rv[1] = 0;
            rv[2] = d[0];
            ok = unit_vector(d, f);
            if (ok)
                ok = unit_vector(rv, r);
            if (ok)
            begin
                uv[0] = r[1] * f[2] - f[1] * r[2];
                uv[1] = r[2] * f[0] - f[2] * r[0];
                uv[2] = r[0] * f[1] - f[0] * r[1];
                ok = unit_vector(uv, u);
            end
            for (int c = 0; c < 4; c++)
                for (int i = 0; i < 4; i++)
                    mtx[c][i] = '0;
            if (ok)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    mtx[c][0] = 32'(r[c]);
                    mtx[c][1] = 32'(u[c]);
                    mtx[c][2] = 32'(-f[c]);
                end
                mtx[3][0] = round_clip(-(r[0] * p[0] + r[1] * p[1] + r[2] * p[2]));
                mtx[3][1] = round_clip(-(u[0] * p[0] + u[1] * p[1] + u[2] * p[2]));
                mtx[3][2] = round_clip(f[0] * p[0] + f[1] * p[1] + f[2] * p[2]);
                mtx[3][3] = ONE_FX;
            end
            for (int c = 0; c < 4; c++)
            begin
                col.column_index = 2'(c);
                col.elem_row0 = mtx[c][0];
                col.elem_row1 = mtx[c][1];
                col.elem_row2 = mtx[c][2];
                col.elem_row3 = mtx[c][3];
                col.last_column = (c == 3);
                col.degenerate = !ok;
                pending_columns.push_back(col);
            end
        endfunction

        // Compare one received column with the oldest expected one.
        function void check_column(input out_item_t got);
            out_item_t exp_col;
            if (pending_columns.size() == 0)
            begin
                $display("%0t: unexpected column %p", $time, got);
                error_count++;
                return;
            end
            exp_col = pending_columns.pop_front();
            if (got.column_index !== exp_col.column_index)
                report_field("column_index", exp_col.column_index, got.column_index);
            if (got.elem_row0 !== exp_col.elem_row0)
                report_field("elem_row0", exp_col.elem_row0, got.elem_row0);
            if (got.elem_row1 !== exp_col.elem_row1)
                report_field("elem_row1", exp_col.elem_row1, got.elem_row1);
            if (got.elem_row2 !== exp_col.elem_row2)
                report_field("elem_row2", exp_col.elem_row2, got.elem_row2);
            if (got.elem_row3 !== exp_col.elem_row3)
                report_field("elem_row3", exp_col.elem_row3, got.elem_row3);
            if (got.last_column !== exp_col.last_column)
                report_field("last_column", exp_col.last_column, got.last_column);
            if (got.degenerate !== exp_col.degenerate)
                report_field("degenerate", exp_col.degenerate, got.degenerate);
        endfunction

        function void report_field(input string name, input logic [31:0] e,
                                   input logic [31:0] a);
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, e, a);
            error_count++;
        endfunction
    endclass

    localparam int CYCLE_LIMIT = 1000000;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;

    column_scoreboard board;
    int send_idle_pct;
    int recv_idle_pct;
    int cycle_count = 0;

    look_at_view_matrix u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_item  (in_item),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_item (out_item)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Receiver: random stalls, check each column transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_column(out_item);
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // Send one transfer, with random idle cycles ahead of it.
    task automatic send_view(input in_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_view(it);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2000)) - 1000) <<< 16;
            2: return 32'h7FFF_FFFF;
            3: return 32'h8000_0000;
            default: return 32'($signed($urandom_range(200000)) - 100000) <<< 8;
        endcase
    endfunction

    // Random view, often with a degenerate or axis-aligned direction.
    function automatic in_item_t rand_view();
        in_item_t it;
        it.pos_x = rand_coord();
        it.pos_y = rand_coord();
        it.pos_z = rand_coord();
        it.target_x = rand_coord();
        it.target_y = rand_coord();
        it.target_z = rand_coord();
        case ($urandom_range(9))
            0: it.target_x = it.pos_x;
            1:
            begin
                it.target_x = it.pos_x;
                it.target_z = it.pos_z;
            end
            2:
            begin
                it.target_x = it.pos_x;
                it.target_y = it.pos_y;
                it.target_z = it.pos_z;
            end
            3: it.target_y = it.pos_y;
            default: ;
        endcase
        return it;
    endfunction

    function automatic in_item_t make_view(input logic [31:0] px, py, pz, tx, ty, tz);
        in_item_t it;
        it.pos_x = px;
        it.pos_y = py;
        it.pos_z = pz;
        it.target_x = tx;
        it.target_y = ty;
        it.target_z = tz;
        return it;
    endfunction

    // Stop sending and wait until every expected column has arrived.
    task automatic drain_columns();
        in_valid <= 1'b0;
        while (board.pending_columns.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus.
    initial
    begin
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: plain views, degenerate cases, extremes.
        send_view(make_view(0, 0, 0, 0, 0, -32'sd65536));
        send_view(make_view(0, 0, 32'sd327680, 0, 0, 0));
        send_view(make_view(32'sd65536, 32'sd131072, 32'sd196608, 0, 0, 0));
        send_view(make_view(5, 6, 7, 5, 6, 7));
        send_view(make_view(0, 0, 0, 0, 32'sd65536, 0));
        send_view(make_view(0, 0, 0, 0, -32'sd65536, 0));
        send_view(make_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_view(make_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        send_view(make_view(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                            32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_view(make_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0));
        send_view(make_view(0, 0, 0, 1, 32'h7FFF_FFFF, 0));
        send_view(make_view(32'h7FFF_FFFF, 0, 32'h8000_0000, 32'h7FFF_FFFE, 0, 32'h8000_0001));
        send_view(make_view(32'h0001_0000, 0, 0, 32'h0001_0000, 32'h0005_0000, 1));
        send_view(make_view(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                            32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA));

        // Hold off until the block has emptied.
        drain_columns();

        send_idle_pct = 35;
        recv_idle_pct = 60;
        repeat (85) send_view(rand_view());
        send_idle_pct = 60;
        recv_idle_pct = 35;
        repeat (85) send_view(rand_view());
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (85) send_view(rand_view());

        drain_columns();
        repeat (500) @(posedge clk);
        if (board.error_count == 0 && board.pending_columns.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
